>>> src/mca_pkg.sv
// Shared types and constants for the mouse click aggregator.
package mca_pkg;

  // Input item kinds.
  localparam logic [1:0] KIND_BUTTON = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_WHEEL  = 2'd2;

  // Buttons that count as a click (left and right).
  localparam logic [7:0]  BUTTON_MASK  = 8'h03;
  localparam logic [15:0] EXTEND_TICKS = 16'd10;
  localparam logic [7:0]  COUNT_MAX    = 8'd255;

  // Configuration port geometry.
  localparam int unsigned PADDR_W     = 3;
  localparam logic [PADDR_W-1:0] ADDR_DCLICK = 3'd0;

  // Result queue depth; one item can push two results.
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        event_time;
    logic [7:0]         button_state;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]         wheel_id;
    logic signed [15:0] wheel_clicks;
  } mca_in_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic [7:0]         accum_state;
    logic [7:0]         current_state;
    logic signed [15:0] clicks;
    logic               last;
  } mca_out_t;

  // Results of one processed item, handed to the result queue.
  typedef struct packed {
    logic [1:0] n;
    mca_out_t   r0;
    mca_out_t   r1;
  } mca_push_t;

endpackage

>>> src/mca_cfg.sv
// APB-style register file holding the double-click window length.
module mca_cfg import mca_pkg::*; #(
  parameter int unsigned MAX_WINDOW = 1000
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic [14:0]        dclick_window_o
);

  logic [14:0] dclick_q, dclick_d;
  logic [14:0] wr_val;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == ADDR_DCLICK);
  assign wr_val = pwdata[14:0];

  // Values above the configured maximum are stored as the maximum.
  always_comb begin
    dclick_d = dclick_q;
    if (wr_en) begin
      if (wr_val > 15'(MAX_WINDOW)) begin
        dclick_d = 15'(MAX_WINDOW);
      end else begin
        dclick_d = wr_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dclick_q <= '0;
    end else begin
      dclick_q <= dclick_d;
    end
  end

  assign prdata          = (paddr == ADDR_DCLICK) ? {17'd0, dclick_q} : 32'd0;
  assign dclick_window_o = dclick_q;

endmodule

>>> src/mca_step.sv
// Input register, click window state and the per-item step logic.
module mca_step import mca_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  mca_in_t     in_data_i,
  input  logic        room_i,
  input  logic [14:0] dclick_window_i,
  output mca_push_t   push_o
);

  logic      in_valid_q;
  mca_in_t   in_q;
  logic      adv;

  logic [7:0]  prev_q, prev_d;
  logic [15:0] wl_q, wl_d;
  logic [15:0] ws_q, ws_d;
  logic [15:0] hx_q, hx_d;
  logic [15:0] hy_q, hy_d;
  logic [7:0]  ha_q, ha_d;
  logic [7:0]  hc_q, hc_d;
  logic [7:0]  cnt_q, cnt_d;

  logic [15:0] elapsed;
  logic [15:0] wl_aged;
  logic        close;
  logic [1:0]  n;
  mca_out_t    r0, r1, pkt_held, pkt_rel;

  assign adv        = in_valid_q && room_i;
  assign in_ready_o = !in_valid_q || room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // 16-bit wrapping window aging; a zero or negative remainder closes it.
  assign elapsed  = in_q.event_time - ws_q;
  assign wl_aged  = wl_q - elapsed;
  assign close    = (wl_q != 16'd0) && ((wl_aged == 16'd0) || wl_aged[15]);
  assign pkt_held = '{out_x: hx_q, out_y: hy_q, accum_state: ha_q, current_state: hc_q,
                      clicks: {8'd0, cnt_q}, last: 1'b0};
  assign pkt_rel  = '{out_x: in_q.pos_x, out_y: in_q.pos_y,
                      accum_state: in_q.button_state, current_state: in_q.button_state,
                      clicks: 16'd0, last: 1'b0};

  always_comb begin
    prev_d = prev_q;
    wl_d   = wl_q;
    ws_d   = ws_q;
    hx_d   = hx_q;
    hy_d   = hy_q;
    ha_d   = ha_q;
    hc_d   = hc_q;
    cnt_d  = cnt_q;
    n      = 2'd0;
    r0     = '0;
    r1     = '0;

    if ((in_q.kind == KIND_BUTTON) || (in_q.kind == KIND_TICK)) begin
      if (wl_q != 16'd0) begin
        ws_d = in_q.event_time;
        wl_d = close ? 16'd0 : wl_aged;
      end
      if (close) begin
        r0 = pkt_held;
        n  = 2'd1;
      end
    end

    if ((in_q.kind == KIND_BUTTON) && (in_q.button_state != prev_q)) begin
      prev_d = in_q.button_state;
      if (wl_d != 16'd0) begin
        // Change inside an open window.
        ha_d = ha_q | in_q.button_state;
        hc_d = in_q.button_state;
        if (((in_q.button_state & BUTTON_MASK) != 8'd0) && (cnt_q != COUNT_MAX)) begin
          cnt_d = cnt_q + 8'd1;
        end
        if (cnt_d > 8'd1) begin
          wl_d = wl_d + EXTEND_TICKS;
        end
      end else begin
        ha_d = in_q.button_state;
        hc_d = in_q.button_state;
        hx_d = in_q.pos_x;
        hy_d = in_q.pos_y;
        if ((in_q.button_state & BUTTON_MASK) != 8'd0) begin
          ws_d  = in_q.event_time;
          wl_d  = {1'b0, dclick_window_i};
          cnt_d = 8'd1;
        end else begin
          // A change with no click button and no window goes out at once.
          cnt_d = 8'd0;
          wl_d  = 16'd0;
          if (n == 2'd0) begin
            r0 = pkt_rel;
          end else begin
            r1 = pkt_rel;
          end
          n = n + 2'd1;
        end
      end
    end

    if (in_q.kind == KIND_WHEEL) begin
      r0 = '{out_x: in_q.pos_x, out_y: in_q.pos_y, accum_state: in_q.wheel_id,
             current_state: in_q.wheel_id, clicks: in_q.wheel_clicks, last: 1'b0};
      n  = 2'd1;
    end

    if (n == 2'd1) begin
      r0.last = 1'b1;
    end
    if (n == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      wl_q   <= '0;
      ws_q   <= '0;
      hx_q   <= '0;
      hy_q   <= '0;
      ha_q   <= '0;
      hc_q   <= '0;
      cnt_q  <= '0;
    end else if (adv) begin
      prev_q <= prev_d;
      wl_q   <= wl_d;
      ws_q   <= ws_d;
      hx_q   <= hx_d;
      hy_q   <= hy_d;
      ha_q   <= ha_d;
      hc_q   <= hc_d;
      cnt_q  <= cnt_d;
    end
  end

  assign push_o.n  = adv ? n : 2'd0;
  assign push_o.r0 = r0;
  assign push_o.r1 = r1;

  // An open window always has at least one counted click behind it.
  a_open_has_click: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wl_q != 16'd0) |-> (cnt_q != 8'd0))
    else $error("click window open with zero click count");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.n == 2'd1) |-> push_o.r0.last)
    else $error("single result not marked last");

  a_pair_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.n == 2'd2) |-> (!push_o.r0.last && push_o.r1.last))
    else $error("result pair marked wrongly");

endmodule

>>> src/mca_outq.sv
// Result queue: up to two in per cycle if it has room, one out when ready.
module mca_outq import mca_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  mca_push_t push_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output mca_out_t  out_data_o
);

  mca_out_t            mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_q, rd_q;
  logic [Q_CNT_W-1:0]  cnt_q;
  logic                pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rd_q];
  assign room_o      = cnt_q <= Q_CNT_W'(Q_DEPTH - 2);

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_q + Q_PTR_W'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + Q_PTR_W'(push_i.n);
      rd_q  <= rd_q + Q_PTR_W'(pop);
      cnt_q <= cnt_q + Q_CNT_W'(push_i.n) - Q_CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.n != 2'd0) |-> room_o)
    else $error("result queue written without room");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Q_CNT_W'(Q_DEPTH))
    else $error("result queue count out of range");

endmodule

>>> src/mouse_click_aggregator_top.sv
// Top level of the mouse click aggregator.
//
// While in_ready_o is high, the block takes one event transaction per cycle
// on the input channel (in_valid_i / in_ready_o / in_data_i): button
// events, timer ticks and wheel events. Each transaction yields zero, one
// or two result transactions on the output channel (out_valid_o /
// out_ready_i / out_data_o); the final result of an event carries last set.
// An accepted event sits in an input register until the queue has room
// for two results, is processed by a single pass of compare-and-add logic
// against the click window state, and its results land in a four-entry
// result queue, which offers them one at a time and in order.
// Sustained throughput is one event per cycle while the receiver takes one
// result per cycle and events average no more than one result each; the
// input register is released only when the queue has room for two results.
// When the receiver stalls, the queue fills and in_ready_o drops until
// results drain; nothing is lost or dropped. Reset clears the window state,
// the queue and the window length register (zero, so no window opens until
// software writes one). The window length is written over the APB-style
// port at byte address 0 and is clamped to MAX_WINDOW.
module mouse_click_aggregator_top import mca_pkg::*; #(
  parameter int unsigned MAX_WINDOW = 1000
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mca_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mca_out_t           out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [14:0] dclick_window;
  logic        room;
  mca_push_t   push;

  // Config register: user writes only while the block is idle; unenforced.
  mca_cfg #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .dclick_window_o(dclick_window)
  );

  // Event processing: input register plus click window state.
  mca_step u_step (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_data_i      (in_data_i),
    .room_i         (room),
    .dclick_window_i(dclick_window),
    .push_o         (push)
  );

  // Result queue decouples the event side from a stalling receiver.
  mca_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the mouse click aggregator: directed and random event traffic.
module tb_top import mca_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Clock, run length and block geometry.
  localparam int unsigned CLK_PERIOD    = 20;
  localparam int unsigned RESET_CYCLES  = 8;
  localparam int unsigned MAX_WIN       = 1000;
  // The block registers each accepted event and then queues its results before it
  // offers them. An event that causes nothing leaves no trace, so before a register
  // write we let the block settle further, so that such an event has passed through.
  localparam int unsigned SETTLE_CYCLES = 8;
  // The slowest correct run is about 2000 events plus the long hold-off. This
  // limit is many times that.
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned MAX_PER_EVENT = 2;

  // The package names three kinds. The fourth code is unused and must be ignored.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // ---------------------------------------------------------------------------
  // DUT connections. Every input has a known value from time zero.
  // ---------------------------------------------------------------------------
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  mca_in_t            in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  mca_out_t           out_data_o;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [31:0]        pwdata      = '0;
  logic [31:0]        prdata;
  logic               pready;

  mouse_click_aggregator_top #(
    .MAX_WINDOW (MAX_WIN)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Testbench bookkeeping.
  // ---------------------------------------------------------------------------
  mca_in_t  pending_events[$];   // Events waiting to be offered to the block.
  mca_out_t click_exp_q[$];      // Packets the block still owes us, oldest first.
  mca_out_t step_pkts[$];        // Packets caused by the event being predicted.

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned err_count       = 0;
  int unsigned cycle_count     = 0;
  bit          hold_req        = 1'b0;

  // Generator state: time stamp of the last event, button mask of the last button event.
  logic [15:0] stim_time    = '0;
  logic [7:0]  stim_buttons = '0;

  // ---------------------------------------------------------------------------
  // Predictor state. It mirrors the block's click window and holding registers
  // and starts at the reset values, zero everywhere.
  // ---------------------------------------------------------------------------
  logic [15:0] win_len_model = '0;   // Window length register after clamping.
  logic [7:0]  prev_btn      = '0;   // Button mask of the last button event.
  logic [15:0] win_left      = '0;   // Ticks left; nonzero means a window is open.
  logic [15:0] win_stamp     = '0;   // Time at which the window was last opened or aged.
  logic [15:0] held_x        = '0;
  logic [15:0] held_y        = '0;
  logic [7:0]  held_acc      = '0;
  logic [7:0]  held_cur      = '0;
  logic [7:0]  held_cnt      = '0;

  // Adds one packet to those caused by the current event. No event causes more
  // than two.
  function automatic void add_packet(logic [15:0] x, logic [15:0] y, logic [7:0] acc,
                                     logic [7:0] cur, logic [15:0] cnt);
    mca_out_t pkt;
    if (step_pkts.size() < MAX_PER_EVENT) begin
      pkt.out_x         = x;
      pkt.out_y         = y;
      pkt.accum_state   = acc;
      pkt.current_state = cur;
      pkt.clicks        = cnt;
      pkt.last          = 1'b0;
      step_pkts.push_back(pkt);
    end
  endfunction

  // Sends out what the window has collected and closes it.
  function automatic void emit_held_click();
    add_packet(held_x, held_y, held_acc, held_cur, {8'h00, held_cnt});
    win_left = '0;
  endfunction

  // Charges the time since the last stamp against an open window. The difference
  // wraps at 16 bits, so a clock that runs backwards lengthens the window. A
  // window that is used up or has gone negative is closed.
  function automatic void age_click_window(logic [15:0] now);
    logic [15:0] elapsed;
    if (win_left != '0) begin
      elapsed   = now - win_stamp;
      win_stamp = now;
      win_left  = win_left - elapsed;
      if (win_left == '0 || win_left[15]) begin
        emit_held_click();
      end
    end
  endfunction

  // Works out the packets that one accepted event causes and queues them in order.
  function automatic void predict_event(mca_in_t ev);
    mca_out_t pkt;
    logic [7:0] s;
    s = ev.button_state;
    step_pkts.delete();
    case (ev.kind)
      KIND_BUTTON: begin
        age_click_window(ev.event_time);
        if (s != prev_btn) begin
          prev_btn = s;
          if (win_left != '0) begin
            // Another change inside an open window.
            held_acc = held_acc | s;
            held_cur = s;
            if ((s & BUTTON_MASK) != '0 && held_cnt < COUNT_MAX) begin
              held_cnt = held_cnt + 8'd1;
            end
            if (held_cnt > 8'd1) begin
              win_left = win_left + EXTEND_TICKS;
            end
          end else begin
            held_acc = s;
            held_cur = s;
            held_x   = ev.pos_x;
            held_y   = ev.pos_y;
            if ((s & BUTTON_MASK) != '0) begin
              // A press opens a window. A zero length opens none.
              win_stamp = ev.event_time;
              win_left  = win_len_model;
              held_cnt  = 8'd1;
            end else begin
              // A change without a click button and no window goes out at once.
              held_cnt = '0;
              emit_held_click();
            end
          end
        end
      end
      KIND_TICK: begin
        age_click_window(ev.event_time);
      end
      KIND_WHEEL: begin
        add_packet(ev.pos_x, ev.pos_y, ev.wheel_id, ev.wheel_id, ev.wheel_clicks);
      end
      default: begin
      end
    endcase
    if (step_pkts.size() > 0) begin
      pkt      = step_pkts.pop_back();
      pkt.last = 1'b1;
      step_pkts.push_back(pkt);
    end
    foreach (step_pkts[i]) begin
      click_exp_q.push_back(step_pkts[i]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. At each rising edge it books the transaction that completed. If the
  // channel is free (valid is low, or the current item was just taken), it then
  // offers the next pending event or goes idle; else it holds the current item.
  // Only then does the valid signal receive a nonblocking assignment, one per edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_event(in_data_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_events.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_data_i  <= pending_events.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver ready. Stalls at random. On request it also holds off for a long
  // stretch that it counts here, so the result queue fills and the input stalls.
  // ---------------------------------------------------------------------------
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Each result transaction is compared field by field with the oldest
  // expected packet.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    mca_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (click_exp_q.size() == 0) begin
        $error("result with no expected packet: %p", out_data_o);
        err_count++;
      end else begin
        want = click_exp_q.pop_front();
        if (out_data_o.out_x !== want.out_x) begin
          $error("out_x: expected %0d, got %0d", want.out_x, out_data_o.out_x);
          err_count++;
        end
        if (out_data_o.out_y !== want.out_y) begin
          $error("out_y: expected %0d, got %0d", want.out_y, out_data_o.out_y);
          err_count++;
        end
        if (out_data_o.accum_state !== want.accum_state) begin
          $error("accum_state: expected 0x%02h, got 0x%02h",
                 want.accum_state, out_data_o.accum_state);
          err_count++;
        end
        if (out_data_o.current_state !== want.current_state) begin
          $error("current_state: expected 0x%02h, got 0x%02h",
                 want.current_state, out_data_o.current_state);
          err_count++;
        end
        if (out_data_o.clicks !== want.clicks) begin
          $error("clicks: expected %0d, got %0d", want.clicks, out_data_o.clicks);
          err_count++;
        end
        if (out_data_o.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_data_o.last);
          err_count++;
        end
      end
    end
  end

  // Watchdog. A hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Writes the window length register with a setup phase and then an access phase.
  // The predictor takes the clamped value once the access completes.
  task automatic write_window_len(input logic [31:0] value);
    logic [15:0] v;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_DCLICK;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    v = {1'b0, value[14:0]};
    win_len_model = (v > MAX_WIN) ? 16'(MAX_WIN) : v;
  endtask

  // Waits until every event has been taken and every packet has arrived, then
  // lets the block settle.
  task automatic wait_quiet();
    do begin
      @(negedge clk_i);
    end while (pending_events.size() > 0 || in_valid_i || click_exp_q.size() > 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic push_event(input logic [1:0] kind, input logic [15:0] t,
                            input logic [7:0] btn, input logic [15:0] x,
                            input logic [15:0] y, input logic [7:0] wid,
                            input logic [15:0] wclk);
    mca_in_t ev;
    ev.kind         = kind;
    ev.event_time   = t;
    ev.button_state = btn;
    ev.pos_x        = x;
    ev.pos_y        = y;
    ev.wheel_id     = wid;
    ev.wheel_clicks = wclk;
    pending_events.push_back(ev);
    stim_time = t;
    if (kind == KIND_BUTTON) begin
      stim_buttons = btn;
    end
  endtask

  // Moves the generator clock. Most steps are short compared with the window,
  // some outlast it, a few jump anywhere, and a few run backwards.
  task automatic advance_time();
    int unsigned sel;
    int          delta;
    sel = $urandom_range(99);
    if (sel < 60) begin
      delta = $urandom_range(0, win_len_model / 8 + 2);
    end else if (sel < 85) begin
      delta = $urandom_range(0, 2 * win_len_model + 20);
    end else if (sel < 95) begin
      delta = $urandom;
    end else begin
      delta = -$urandom_range(1, 50);
    end
    stim_time = stim_time + delta[15:0];
  endtask

  // Random traffic. Mostly presses and releases of the click buttons with
  // timer ticks between them, plus wheel events and some noise.
  task automatic gen_random_events(input int unsigned count);
    int unsigned sel;
    int unsigned bsel;
    logic [7:0]  nb;
    repeat (count) begin
      advance_time();
      sel = $urandom_range(99);
      if (sel < 68) begin
        bsel = $urandom_range(99);
        if (bsel < 70) begin
          nb = stim_buttons ^ (8'h01 << $urandom_range(0, 1));
        end else if (bsel < 78) begin
          nb = 8'h00;
        end else if (bsel < 90) begin
          nb = 8'($urandom);
        end else begin
          nb = stim_buttons;
        end
        push_event(KIND_BUTTON, stim_time, nb, 16'($urandom), 16'($urandom),
                   8'($urandom), 16'($urandom));
      end else if (sel < 88) begin
        push_event(KIND_TICK, stim_time, 8'($urandom), 16'($urandom), 16'($urandom),
                   8'($urandom), 16'($urandom));
      end else if (sel < 97) begin
        push_event(KIND_WHEEL, stim_time, 8'($urandom), 16'($urandom), 16'($urandom),
                   8'($urandom), 16'($urandom));
      end else begin
        push_event(KIND_UNUSED, stim_time, 8'($urandom), 16'($urandom), 16'($urandom),
                   8'($urandom), 16'($urandom));
      end
    end
  endtask

  // A long run of rapid clicks inside one window, enough to saturate the count.
  task automatic gen_click_burst(input int unsigned count);
    logic [7:0] nb;
    nb = 8'h01;
    repeat (count) begin
      stim_time = stim_time + 16'($urandom_range(0, 3));
      push_event(KIND_BUTTON, stim_time, nb, 16'($urandom), 16'($urandom),
                 8'($urandom), 16'($urandom));
      nb = (nb == 8'h01) ? 8'h03 : 8'h01;
    end
    push_event(KIND_BUTTON, stim_time + 16'd2, 8'h00, 16'($urandom), 16'($urandom),
               8'h00, 16'h0000);
    push_event(KIND_TICK, stim_time + 16'd20000, 8'h00, 16'h0000, 16'h0000,
               8'h00, 16'h0000);
  endtask

  task automatic run_random_phase(input logic [31:0] win_value, input int unsigned idle,
                                  input int unsigned stall, input int unsigned count);
    wait_quiet();
    write_window_len(win_value);
    @(negedge clk_i);
    sender_idle_pct = idle;
    recv_stall_pct  = stall;
    gen_random_events(count);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, first with the window length still at its reset value of
    // zero: a press opens nothing and the release reports a count of zero.
    push_event(KIND_BUTTON, 16'd0, 8'h01, 16'h8000, 16'h7FFF, 8'h00, 16'h0000);
    push_event(KIND_BUTTON, 16'd5, 8'h00, 16'h1234, 16'h5678, 8'h00, 16'h0000);
    // Wheel events pass through, with the extremes of every field.
    push_event(KIND_WHEEL, 16'd6, 8'h00, 16'h7FFF, 16'h8000, 8'hFF, 16'h8000);
    push_event(KIND_WHEEL, 16'd7, 8'hFF, 16'h0000, 16'h0000, 8'h00, 16'h7FFF);
    // The unused kind changes nothing, even with every field at all ones.
    push_event(KIND_UNUSED, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
    wait_quiet();
    write_window_len(32'd100);
    @(negedge clk_i);
    // A press, a tick inside the window, more clicks, an unchanged state, a
    // release, then a tick that closes the window.
    push_event(KIND_BUTTON, 16'd10, 8'h01, 16'h0010, 16'hFFF0, 8'h00, 16'h0000);
    push_event(KIND_TICK, 16'd50, 8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000);
    push_event(KIND_BUTTON, 16'd60, 8'h03, 16'h0000, 16'h0000, 8'h00, 16'h0000);
    push_event(KIND_BUTTON, 16'd70, 8'h03, 16'h0000, 16'h0000, 8'h00, 16'h0000);
    push_event(KIND_BUTTON, 16'd75, 8'h02, 16'h0000, 16'h0000, 8'h00, 16'h0000);
    push_event(KIND_BUTTON, 16'd80, 8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000);
    push_event(KIND_TICK, 16'd400, 8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000);
    // Closing then reopening on one event, then closing followed by an
    // immediate release packet, which gives two packets for one event.
    push_event(KIND_BUTTON, 16'd500, 8'h01, 16'h0100, 16'h0200, 8'h00, 16'h0000);
    push_event(KIND_BUTTON, 16'd700, 8'h02, 16'h0300, 16'h0400, 8'h00, 16'h0000);
    push_event(KIND_BUTTON, 16'd900, 8'h00, 16'h0500, 16'h0600, 8'h00, 16'h0000);
    // A timer that wraps, a clock that runs backwards, and a jump large enough
    // to drive the remaining window negative.
    push_event(KIND_BUTTON, 16'd65530, 8'hFF, 16'hFFFF, 16'h0001, 8'h00, 16'h0000);
    push_event(KIND_TICK, 16'd20, 8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000);
    push_event(KIND_TICK, 16'd0, 8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000);
    push_event(KIND_TICK, 16'h8000, 8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000);
    push_event(KIND_BUTTON, 16'h8010, 8'h80, 16'h0042, 16'h0024, 8'h00, 16'h0000);
    push_event(KIND_BUTTON, 16'h8020, 8'h81, 16'h00AA, 16'h0055, 8'h00, 16'h0000);
    push_event(KIND_BUTTON, 16'hFFFF, 8'h7E, 16'h0055, 16'h00AA, 8'h00, 16'h0000);

    // Random phases, each with its own window setting and idling pattern.
    // The first phase has no idling, and the receiver holds off for a long
    // stretch while the sender keeps offering events.
    wait_quiet();
    write_window_len(32'd300);
    @(negedge clk_i);
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    gen_random_events(300);
    hold_req = 1'b1;

    run_random_phase(32'h0000_7FFF, 85, 0, 250);   // Clamped to the maximum.
    run_random_phase(32'd1, 0, 85, 250);
    run_random_phase(32'h0000_8000, 16, 16, 200);  // Upper bits drop: zero.
    run_random_phase(32'd50, 16, 16, 250);
    gen_click_burst(300);
    run_random_phase(32'hFFFF_FFFF, 0, 0, 200);

    wait_quiet();
    if (click_exp_q.size() > 0) begin
      $error("%0d expected packets never arrived", click_exp_q.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
